// File: sv/hta_pkg.sv
// Shared constants and types for the Hall tachometer with moving average.
// No dependencies; used by every module of the block.
package hta_pkg;

	localparam int AVG_DEPTH_DEF = 10;
	localparam int DIV_W = 32;

	localparam int MIN_PERIOD_W = 20;
	localparam int WINDOW_W = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 20;

	localparam int TIME_W = 32;
	localparam int FREQ_W = 20;
	localparam int HELD_W = 4;
	localparam int EDGES_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'd1;

	localparam logic [MIN_PERIOD_W-1:0] MIN_PERIOD_RST = 20'd1000;
	localparam logic [WINDOW_W-1:0] WINDOW_RST = 16'd1000;

	localparam logic [DIV_W-1:0] FREQ_NUMERATOR = 32'd1_000_000_000;
	localparam int FREQ_MAX_INT = 999_999;
	localparam logic [FREQ_W-1:0] FREQ_MAX = 20'd999_999;
	localparam logic [EDGES_W-1:0] EDGE_MAX = 16'hFFFF;

endpackage

// File: sv/hall_tachometer_moving_average.sv
// Hall sensor period tachometer with a moving average of the frequency.
// Uses hta_pkg and instantiates hta_div, the one divider shared by both divisions.
//
//   channel  direction  handshake           payload
//   in       sink       in_valid/in_stall   hall_level, time_us, time_ms
//   out      source     out_valid/out_stall edge_seen ... edges_in_window
//   cfg      sink       cfg_wr_en           cfg_index, cfg_data
//
// Counted from one input acceptance to the next: a sample with no accepted period
// takes one pass of the shared divider for the average, or no pass while the ring is
// still empty; one that adds a frequency takes two passes.
// The block takes one beat at a time; in_stall is high from acceptance until the
// result has moved into the output register, which holds while out_stall is high.
// Reset clears all control state; the frequency ring needs no clearing.
module hall_tachometer_moving_average #(
	parameter int AVG_DEPTH = hta_pkg::AVG_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               hall_level,
	input  logic [hta_pkg::TIME_W-1:0]         time_us,
	input  logic [hta_pkg::TIME_W-1:0]         time_ms,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               edge_seen,
	output logic                               sample_added,
	output logic [hta_pkg::FREQ_W-1:0]         latest_freq_mhz,
	output logic [hta_pkg::FREQ_W-1:0]         average_freq_mhz,
	output logic [hta_pkg::HELD_W-1:0]         samples_held,
	output logic                               window_report,
	output logic [hta_pkg::EDGES_W-1:0]        edges_in_window,
	input  logic                               cfg_wr_en,
	input  logic [hta_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [hta_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import hta_pkg::*;

	localparam int PTR_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
	localparam int CNT_W = $clog2(AVG_DEPTH + 1);
	localparam int SUM_W = $clog2(AVG_DEPTH * FREQ_MAX_INT + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_FREQ,
		ST_RING,
		ST_AVG,
		ST_DIV_AVG,
		ST_OUT
	} state_t;

	state_t state_q;

	logic [MIN_PERIOD_W-1:0] min_period_q;
	logic [WINDOW_W-1:0]     window_q;

	logic                    prev_level_q;
	logic [TIME_W-1:0]       last_edge_q;
	logic                    edge_valid_q;
	logic [PTR_W-1:0]        ptr_q;
	logic [CNT_W-1:0]        fill_q;
	logic [SUM_W-1:0]        sum_q;
	logic [TIME_W-1:0]       win_start_q;
	logic [EDGES_W-1:0]      win_edges_q;
	logic [FREQ_W-1:0]       latest_q;

	logic                    edge_q;
	logic                    added_q;
	logic                    report_q;
	logic [EDGES_W-1:0]      reported_q;
	logic [FREQ_W-1:0]       avg_q;

	logic                    out_valid_q;
	logic                    out_edge_q;
	logic                    out_added_q;
	logic [FREQ_W-1:0]       out_latest_q;
	logic [FREQ_W-1:0]       out_avg_q;
	logic [HELD_W-1:0]       out_held_q;
	logic                    out_report_q;
	logic [EDGES_W-1:0]      out_edges_q;

	logic                    div_start_q;
	logic [DIV_W-1:0]        div_a_q;
	logic [DIV_W-1:0]        div_b_q;
	logic                    div_done;
	logic [DIV_W-1:0]        div_quot;

	logic [FREQ_W-1:0]       ring_mem [AVG_DEPTH];
	logic [FREQ_W-1:0]       ring_rd_q;

	logic                    in_beat;
	logic                    is_edge;
	logic [TIME_W-1:0]       period;
	logic                    take_period;
	logic [EDGES_W-1:0]      edges_next;
	logic                    expired;
	logic [FREQ_W-1:0]       freq_new;
	logic                    ring_full;
	logic                    out_free;

	assign in_beat = in_valid && !in_stall;
	assign is_edge = !hall_level && prev_level_q;
	assign period = time_us - last_edge_q;
	assign take_period = is_edge && edge_valid_q && (period > TIME_W'(min_period_q));
	assign edges_next = (is_edge && win_edges_q != EDGE_MAX) ? win_edges_q + 1'b1 : win_edges_q;
	assign expired = (time_ms - win_start_q) >= TIME_W'(window_q);
	assign freq_new = (div_quot > DIV_W'(FREQ_MAX)) ? FREQ_MAX : div_quot[FREQ_W-1:0];
	assign ring_full = (fill_q == CNT_W'(AVG_DEPTH));
	assign out_free = !out_valid_q || !out_stall;

	assign in_stall = (state_q != ST_IDLE);

	hta_div #(
		.W(DIV_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start_q),
		.dividend(div_a_q),
		.divisor(div_b_q),
		.done(div_done),
		.quotient(div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_period_q <= MIN_PERIOD_RST;
			window_q <= WINDOW_RST;
		end else if (cfg_wr_en) begin
			if (cfg_index == REG_MIN_PERIOD) begin
				min_period_q <= cfg_data[MIN_PERIOD_W-1:0];
			end else if (cfg_index == REG_WINDOW) begin
				window_q <= cfg_data[WINDOW_W-1:0];
			end
		end
	end

	// The read port follows the ring pointer, so the entry about to be replaced is
	// already registered by the time the new frequency comes out of the divider.
	always_ff @(posedge clk) begin
		if (state_q == ST_RING) begin
			ring_mem[ptr_q] <= freq_new;
		end
		ring_rd_q <= ring_mem[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			prev_level_q <= 1'b1;
			last_edge_q <= '0;
			edge_valid_q <= 1'b0;
			ptr_q <= '0;
			fill_q <= '0;
			sum_q <= '0;
			win_start_q <= '0;
			win_edges_q <= '0;
			latest_q <= '0;
			edge_q <= 1'b0;
			added_q <= 1'b0;
			report_q <= 1'b0;
			reported_q <= '0;
			avg_q <= '0;
			div_start_q <= 1'b0;
			div_a_q <= '0;
			div_b_q <= '0;
			out_valid_q <= 1'b0;
			out_edge_q <= 1'b0;
			out_added_q <= 1'b0;
			out_latest_q <= '0;
			out_avg_q <= '0;
			out_held_q <= '0;
			out_report_q <= 1'b0;
			out_edges_q <= '0;
		end else begin
			div_start_q <= 1'b0;
			// A result leaving while the next one loads is handled in ST_OUT.
			if (out_valid_q && !out_stall && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						prev_level_q <= hall_level;
						edge_q <= is_edge;
						added_q <= 1'b0;
						if (is_edge) begin
							last_edge_q <= time_us;
							edge_valid_q <= 1'b1;
						end
						if (expired) begin
							report_q <= 1'b1;
							reported_q <= edges_next;
							win_edges_q <= '0;
							win_start_q <= time_ms;
						end else begin
							report_q <= 1'b0;
							reported_q <= '0;
							win_edges_q <= edges_next;
						end
						if (take_period) begin
							div_a_q <= FREQ_NUMERATOR;
							div_b_q <= period;
							div_start_q <= 1'b1;
							state_q <= ST_DIV_FREQ;
						end else begin
							state_q <= ST_AVG;
						end
					end
				end
				ST_DIV_FREQ: begin
					if (div_done) begin
						state_q <= ST_RING;
					end
				end
				ST_RING: begin
					latest_q <= freq_new;
					added_q <= 1'b1;
					if (ring_full) begin
						sum_q <= sum_q + SUM_W'(freq_new) - SUM_W'(ring_rd_q);
					end else begin
						sum_q <= sum_q + SUM_W'(freq_new);
						fill_q <= fill_q + 1'b1;
					end
					if (ptr_q == PTR_W'(AVG_DEPTH - 1)) begin
						ptr_q <= '0;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
					state_q <= ST_AVG;
				end
				ST_AVG: begin
					if (fill_q == '0) begin
						avg_q <= '0;
						state_q <= ST_OUT;
					end else begin
						div_a_q <= DIV_W'(sum_q);
						div_b_q <= DIV_W'(fill_q);
						div_start_q <= 1'b1;
						state_q <= ST_DIV_AVG;
					end
				end
				ST_DIV_AVG: begin
					if (div_done) begin
						avg_q <= div_quot[FREQ_W-1:0];
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_edge_q <= edge_q;
						out_added_q <= added_q;
						out_latest_q <= latest_q;
						out_avg_q <= avg_q;
						out_held_q <= HELD_W'(fill_q);
						out_report_q <= report_q;
						out_edges_q <= reported_q;
						state_q <= ST_IDLE;
					end else if (!out_stall) begin
						out_valid_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign edge_seen = out_edge_q;
	assign sample_added = out_added_q;
	assign latest_freq_mhz = out_latest_q;
	assign average_freq_mhz = out_avg_q;
	assign samples_held = out_held_q;
	assign window_report = out_report_q;
	assign edges_in_window = out_edges_q;

endmodule

// File: sv/hta_div.sv
// Restoring divider that retires one quotient bit per cycle.
// Uses hta_pkg for its default width; shared by both divisions of the tachometer.
module hta_div #(
	parameter int W = hta_pkg::DIV_W
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient
);
	localparam int CNT_W = $clog2(W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     dsr_q;
	logic [W:0]       rem_sh;
	logic [W:0]       diff;

	// The shifted remainder stays below twice the divisor, so one subtract decides the bit.
	assign rem_sh = {rem_q, quo_q[W-1]};
	assign diff = rem_sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

// File: sv/hta_checker.sv
// Port-level checks for the Hall tachometer, bound to the top level.
// Uses hta_pkg for port widths; depends on hall_tachometer_moving_average.
module hta_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic                           edge_seen,
	input logic                           sample_added,
	input logic [hta_pkg::FREQ_W-1:0]     latest_freq_mhz,
	input logic                           window_report,
	input logic [hta_pkg::EDGES_W-1:0]    edges_in_window
);
	import hta_pkg::*;

	// The block works on one beat at a time, so it must stall right after taking one.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a sample was still in work");

	// A frequency only comes from a falling edge of the sensor level.
	a_added_needs_edge: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sample_added |-> edge_seen)
		else $error("frequency added without an edge");

	a_count_only_on_report: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !window_report |-> edges_in_window == '0)
		else $error("edge count shown without a window report");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(latest_freq_mhz))
		else $error("stalled result beat changed");

endmodule

bind hall_tachometer_moving_average hta_checker u_hta_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.edge_seen(edge_seen),
	.sample_added(sample_added),
	.latest_freq_mhz(latest_freq_mhz),
	.window_report(window_report),
	.edges_in_window(edges_in_window)
);
